// ===== rtl/pgh_pkg.sv =====
// shared types and constants of the particle grid histogram
package pgh_pkg;

  localparam int COORD_W   = 32;
  localparam int COUNT_W   = 32;
  localparam int ADDR_W    = 12;
  localparam int DEPTH     = 4096;
  localparam int CELL_W    = 8;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_Z = 3'd5;

  localparam logic signed [COORD_W-1:0] LOW_RESET  = 32'sd0;
  localparam logic signed [COORD_W-1:0] HIGH_RESET = 32'sd4194304;
  localparam logic [COUNT_W-1:0]        COUNT_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [ADDR_W-1:0]         read_bin;
  } in_item_t;

  typedef struct packed {
    logic                inside_grid;
    logic [ADDR_W-1:0]   bin_index;
    logic [COUNT_W-1:0]  bin_count;
  } out_item_t;

  typedef struct packed {
    logic              done;
    logic              in_range;
    logic [CELL_W-1:0] cell_idx;
  } axis_stat_t;

endpackage

// ===== rtl/pgh_ram.sv =====
// generic single-write, single-read ram with registered read data
module pgh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pgh_axis.sv =====
// per-axis range check and bit-serial restoring division for the cell index
module pgh_axis #(
  parameter int CELLS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [pgh_pkg::COORD_W-1:0] pos,
  input  logic signed [pgh_pkg::COORD_W-1:0] lo,
  input  logic signed [pgh_pkg::COORD_W-1:0] hi,
  output pgh_pkg::axis_stat_t               stat
);

  localparam int CW_  = pgh_pkg::COORD_W;
  localparam int QB   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int NB   = $clog2(CELLS + 1);
  localparam int PW   = CW_ + NB;
  localparam int CNTW = $clog2(QB + 1);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_MUL  = 3'b010,
    A_DIV  = 3'b100
  } ax_state_t;

  ax_state_t          state_r, state_nxt;
  logic [CW_-1:0]     off_r, off_nxt;
  logic [CW_-1:0]     span_r, span_nxt;
  logic               inside_r, inside_nxt;
  logic [CW_-1:0]     rem_r, rem_nxt;
  logic [QB-1:0]      low_r, low_nxt;
  logic [QB-1:0]      quo_r, quo_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;

  logic signed [CW_:0] off_s;
  logic signed [CW_:0] span_s;
  logic [PW-1:0]       prod;
  logic [CW_:0]        trial;
  logic [CW_:0]        diff;
  logic                ge;

  assign off_s  = {pos[CW_-1], pos} - {lo[CW_-1], lo};
  assign span_s = {hi[CW_-1], hi} - {lo[CW_-1], lo};
  assign prod   = PW'(off_r) * PW'(CELLS);
  assign trial  = {rem_r, low_r[QB-1]};
  assign diff   = trial - {1'b0, span_r};
  assign ge     = trial >= {1'b0, span_r};

  always_comb begin
    state_nxt  = state_r;
    off_nxt    = off_r;
    span_nxt   = span_r;
    inside_nxt = inside_r;
    rem_nxt    = rem_r;
    low_nxt    = low_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    if (start) begin
      off_nxt    = off_s[CW_-1:0];
      span_nxt   = span_s[CW_-1:0];
      inside_nxt = (pos >= lo) && (pos < hi);
      state_nxt  = A_MUL;
    end else begin
      case (state_r)
        A_MUL: begin
          rem_nxt   = prod[QB+CW_-1:QB];
          low_nxt   = prod[QB-1:0];
          quo_nxt   = '0;
          cnt_nxt   = CNTW'(QB);
          state_nxt = A_DIV;
        end
        A_DIV: begin
          rem_nxt = ge ? diff[CW_-1:0] : trial[CW_-1:0];
          low_nxt = low_r << 1;
          quo_nxt = QB'({quo_r, ge});
          cnt_nxt = cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            state_nxt = A_IDLE;
          end
        end
        default: begin
          state_nxt = A_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    off_r    <= off_nxt;
    span_r   <= span_nxt;
    inside_r <= inside_nxt;
    rem_r    <= rem_nxt;
    low_r    <= low_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign stat.done     = (state_r == A_IDLE);
  assign stat.in_range = inside_r;
  assign stat.cell_idx = pgh_pkg::CELL_W'(quo_r);

endmodule

// ===== rtl/particle_grid_histogram_core.sv =====
// 3d particle grid histogram: range check, cell division and bin counter store
//
// usage: items arrive on in_valid/in_ready/in_data, results leave on
// out_valid/out_ready/out_data, one result per item, in order. the cfg port
// writes the six grid bounds (cfg_we, cfg_index, cfg_wdata); the user must
// write them only while idle, as the block itself does not enforce it.
// a count item checks the three axes in parallel; each axis finds its cell
// with a restoring divider giving one quotient bit per cycle. a count result
// waits for the divider of the widest axis, then the read-modify-write
// of the bin store; a particle outside the grid skips the store. a read item
// reads the store without writing it, and an unused opcode gives a zero
// result. a clear item sweeps the 4096-entry store one entry per cycle, then
// gives its result. after reset the same sweep runs with in_ready low.
// items are taken one at a time; in_ready rises with out_valid. the result
// sits in an output register, so the next item is accepted while it waits.
// if the receiver stalls with a result held and another one finished, the
// block waits in place.
module particle_grid_histogram_core #(
  parameter int CELLS_X = 16,
  parameter int CELLS_Y = 16,
  parameter int CELLS_Z = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pgh_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pgh_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [pgh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pgh_pkg::COORD_W-1:0]         cfg_wdata
);

  localparam int AW  = pgh_pkg::ADDR_W;
  localparam int CXY = CELLS_X * CELLS_Y;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_AXIS = 6'b000100,
    S_RD   = 6'b001000,
    S_UPD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   bin_r, bin_nxt;
  logic                            is_read_r, is_read_nxt;
  logic [AW-1:0]                   clr_addr_r, clr_addr_nxt;
  logic                            clr_reply_r, clr_reply_nxt;
  pgh_pkg::out_item_t              res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  pgh_pkg::out_item_t              out_data_r, out_data_nxt;

  logic signed [pgh_pkg::COORD_W-1:0] low_x_r, low_y_r, low_z_r;
  logic signed [pgh_pkg::COORD_W-1:0] high_x_r, high_y_r, high_z_r;

  logic                            in_xfer;
  logic                            ax_start;
  pgh_pkg::axis_stat_t             stat_x, stat_y, stat_z;
  logic [AW-1:0]                   bin_calc;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [pgh_pkg::COUNT_W-1:0]     ram_wdata;
  logic                            ram_re;
  logic [pgh_pkg::COUNT_W-1:0]     ram_rdata;
  logic [pgh_pkg::COUNT_W-1:0]     cnt_new;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign ax_start = in_xfer && (in_data.opcode == pgh_pkg::OP_COUNT);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_x_r  <= pgh_pkg::LOW_RESET;
      low_y_r  <= pgh_pkg::LOW_RESET;
      low_z_r  <= pgh_pkg::LOW_RESET;
      high_x_r <= pgh_pkg::HIGH_RESET;
      high_y_r <= pgh_pkg::HIGH_RESET;
      high_z_r <= pgh_pkg::HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pgh_pkg::CFG_LOW_X:  low_x_r  <= cfg_wdata;
        pgh_pkg::CFG_LOW_Y:  low_y_r  <= cfg_wdata;
        pgh_pkg::CFG_LOW_Z:  low_z_r  <= cfg_wdata;
        pgh_pkg::CFG_HIGH_X: high_x_r <= cfg_wdata;
        pgh_pkg::CFG_HIGH_Y: high_y_r <= cfg_wdata;
        pgh_pkg::CFG_HIGH_Z: high_z_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  pgh_axis #(.CELLS(CELLS_X)) u_axis_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ax_start),
    .pos   (in_data.pos_x),
    .lo    (low_x_r),
    .hi    (high_x_r),
    .stat  (stat_x)
  );

  pgh_axis #(.CELLS(CELLS_Y)) u_axis_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ax_start),
    .pos   (in_data.pos_y),
    .lo    (low_y_r),
    .hi    (high_y_r),
    .stat  (stat_y)
  );

  pgh_axis #(.CELLS(CELLS_Z)) u_axis_z (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ax_start),
    .pos   (in_data.pos_z),
    .lo    (low_z_r),
    .hi    (high_z_r),
    .stat  (stat_z)
  );

  // row-major bin, wrapped to the store depth
  assign bin_calc = AW'(32'(stat_z.cell_idx) * 32'(CXY)
                        + 32'(stat_y.cell_idx) * 32'(CELLS_X)
                        + 32'(stat_x.cell_idx));

  assign cnt_new = (ram_rdata == pgh_pkg::COUNT_MAX) ? ram_rdata
                                                      : ram_rdata + 32'd1;

  pgh_ram #(.WIDTH(pgh_pkg::COUNT_W), .DEPTH(pgh_pkg::DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (bin_r),
    .rdata (ram_rdata)
  );

  assign ram_re    = (state_r == S_RD);
  assign ram_we    = (state_r == S_CLR) || ((state_r == S_UPD) && !is_read_r);
  assign ram_waddr = (state_r == S_CLR) ? clr_addr_r : bin_r;
  assign ram_wdata = (state_r == S_CLR) ? '0 : cnt_new;

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    is_read_nxt   = is_read_r;
    clr_addr_nxt  = clr_addr_r;
    clr_reply_nxt = clr_reply_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_CLR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(pgh_pkg::DEPTH - 1)) begin
          if (clr_reply_r) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data.opcode)
            pgh_pkg::OP_COUNT: begin
              is_read_nxt = 1'b0;
              state_nxt   = S_AXIS;
            end
            pgh_pkg::OP_READ: begin
              bin_nxt     = in_data.read_bin;
              is_read_nxt = 1'b1;
              state_nxt   = S_RD;
            end
            pgh_pkg::OP_CLEAR: begin
              clr_addr_nxt  = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLR;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_AXIS: begin
        if (stat_x.done && stat_y.done && stat_z.done) begin
          if (stat_x.in_range && stat_y.in_range && stat_z.in_range) begin
            bin_nxt   = bin_calc;
            state_nxt = S_RD;
          end else begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_RD: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        res_nxt.bin_index = bin_r;
        if (is_read_r) begin
          res_nxt.inside_grid = 1'b0;
          res_nxt.bin_count   = ram_rdata;
        end else begin
          res_nxt.inside_grid = 1'b1;
          res_nxt.bin_count   = cnt_new;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= (state_r == S_DONE) ? 1'b0 : clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_r      <= bin_nxt;
    is_read_r  <= is_read_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/pgh_check.sv =====
// port-level checker for the particle grid histogram, bound to the top level
module pgh_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input pgh_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input pgh_pkg::out_item_t out_data
);

  // waiting input holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed or dropped while waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // a counted particle always shows a nonzero count
  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_grid |-> out_data.bin_count != '0)
    else $error("counted bin reports zero");

  // store sweep after reset blocks input
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input accepted during reset sweep");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

endmodule

bind particle_grid_histogram_core pgh_check u_check (.*);
